FILE: rtl/nss_pkg.sv
// ----------------------------------------------------------------------------
// nss_pkg
// shared types and constants for the nine-slice source address block
// ----------------------------------------------------------------------------
`default_nettype none

package nss_pkg;

    // largest accepted source dimension
    localparam int MAX_DIM    = 4096;

    localparam int REG_W      = 13;
    localparam int COORD_W    = 12;
    localparam int INDEX_W    = 24;
    localparam int ERR_W      = 3;
    localparam int CFG_IDX_W  = 4;

    // center band divide: (dst - near) * source band / target band
    localparam int NUM_W      = COORD_W + REG_W;
    localparam int DEN_W      = REG_W;
    localparam int QUO_W      = REG_W;
    localparam int DIV_STAGES = QUO_W;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef enum logic [ERR_W-1:0] {
        ERR_OK        = 3'd0,
        ERR_EMPTY_SRC = 3'd1,
        ERR_H_INSET   = 3'd2,
        ERR_V_INSET   = 3'd3,
        ERR_TARGET    = 3'd4,
        ERR_COORD     = 3'd5
    } err_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SRC_WIDTH     = 4'd0,
        REG_SRC_HEIGHT    = 4'd1,
        REG_TARGET_WIDTH  = 4'd2,
        REG_TARGET_HEIGHT = 4'd3,
        REG_INSET_LEFT    = 4'd4,
        REG_INSET_RIGHT   = 4'd5,
        REG_INSET_TOP     = 4'd6,
        REG_INSET_BOTTOM  = 4'd7
    } reg_idx_t;

    typedef struct packed {
        logic [REG_W-1:0] src_width;
        logic [REG_W-1:0] src_height;
        logic [REG_W-1:0] target_width;
        logic [REG_W-1:0] target_height;
        logic [REG_W-1:0] inset_left;
        logic [REG_W-1:0] inset_right;
        logic [REG_W-1:0] inset_top;
        logic [REG_W-1:0] inset_bottom;
    } cfg_t;

    // one axis after classification, before the multiply
    typedef struct packed {
        logic             center;
        logic [REG_W-1:0] base;
        logic [REG_W-1:0] cmax;
        logic [COORD_W-1:0] dn;
        logic [REG_W-1:0] sspan;
        logic [DEN_W-1:0] den;
    } axis_pre_t;

    typedef struct packed {
        err_t      err;
        axis_pre_t ax;
        axis_pre_t ay;
    } pre_item_t;

    // one axis as queued for the back end
    typedef struct packed {
        logic             center;
        logic [REG_W-1:0] base;
        logic [REG_W-1:0] cmax;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } axis_t;

    typedef struct packed {
        err_t  err;
        axis_t ax;
        axis_t ay;
    } item_t;

endpackage

`default_nettype wire

FILE: rtl/nss_front.sv
// ----------------------------------------------------------------------------
// nss_front
// accepts destination coordinates, checks the configuration, classifies
// each axis and forms the center band numerator
// ----------------------------------------------------------------------------
`default_nettype none

module nss_front
    import nss_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire cfg_t               cfg,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [COORD_W-1:0] dst_x,
    input  wire logic [COORD_W-1:0] dst_y,
    input  wire logic               fifo_full,
    output logic                    push,
    output item_t                   push_item
);

    logic      a_valid_reg;
    pre_item_t a_item_reg;
    pre_item_t a_item_next;
    logic      b_valid_reg;
    item_t     b_item_reg;
    item_t     b_item_next;
    logic      a_ready;
    logic      b_ready;
    err_t      err;
    logic [REG_W:0] sum_h;
    logic [REG_W:0] sum_v;

    function automatic axis_pre_t classify(
        input logic [COORD_W-1:0] d,
        input logic [REG_W-1:0]   tgt,
        input logic [REG_W-1:0]   src,
        input logic [REG_W-1:0]   near,
        input logic [REG_W-1:0]   far
    );
        axis_pre_t      r;
        logic [REG_W:0] far_end;
        logic [REG_W-1:0] dn_full;
        far_end  = {2'b00, d} + {1'b0, far};
        dn_full  = {1'b0, d} - near;
        r.center = 1'b0;
        r.base   = '0;
        r.cmax   = src - far - REG_W'(1);
        r.dn     = dn_full[COORD_W-1:0];
        r.sspan  = src - near - far;
        r.den    = tgt - near - far;
        if ({1'b0, d} < near) begin
            r.base = {1'b0, d};
        end else if (far_end >= {1'b0, tgt}) begin
            r.base = src - (tgt - {1'b0, d});
        end else if (r.den == '0 || r.sspan == '0) begin
            r.base = near;
        end else begin
            // stretched offset is added to the near inset in the back end
            r.center = 1'b1;
            r.base   = near;
        end
        return r;
    endfunction

    // config checks in priority order
    always_comb begin
        sum_h = {1'b0, cfg.inset_left} + {1'b0, cfg.inset_right};
        sum_v = {1'b0, cfg.inset_top} + {1'b0, cfg.inset_bottom};
        if (cfg.src_width == '0 || cfg.src_height == '0 ||
            32'(cfg.src_width) > 32'(MAX_DIM) || 32'(cfg.src_height) > 32'(MAX_DIM)) begin
            err = ERR_EMPTY_SRC;
        end else if (sum_h >= {1'b0, cfg.src_width}) begin
            err = ERR_H_INSET;
        end else if (sum_v >= {1'b0, cfg.src_height}) begin
            err = ERR_V_INSET;
        end else if ({1'b0, cfg.target_width} < sum_h ||
                     {1'b0, cfg.target_height} < sum_v) begin
            err = ERR_TARGET;
        end else if ({1'b0, dst_x} >= cfg.target_width ||
                     {1'b0, dst_y} >= cfg.target_height) begin
            err = ERR_COORD;
        end else begin
            err = ERR_OK;
        end
    end

    always_comb begin
        a_item_next.err = err;
        a_item_next.ax  = classify(dst_x, cfg.target_width, cfg.src_width,
                                   cfg.inset_left, cfg.inset_right);
        a_item_next.ay  = classify(dst_y, cfg.target_height, cfg.src_height,
                                   cfg.inset_top, cfg.inset_bottom);
        // errors give zero coordinates through the direct path
        if (err != ERR_OK) begin
            a_item_next.ax.center = 1'b0;
            a_item_next.ax.base   = '0;
            a_item_next.ay.center = 1'b0;
            a_item_next.ay.base   = '0;
        end
    end

    always_comb begin
        b_item_next.err       = a_item_reg.err;
        b_item_next.ax.center = a_item_reg.ax.center;
        b_item_next.ax.base   = a_item_reg.ax.base;
        b_item_next.ax.cmax   = a_item_reg.ax.cmax;
        b_item_next.ax.num    = NUM_W'(a_item_reg.ax.dn) * NUM_W'(a_item_reg.ax.sspan);
        b_item_next.ax.den    = a_item_reg.ax.den;
        b_item_next.ay.center = a_item_reg.ay.center;
        b_item_next.ay.base   = a_item_reg.ay.base;
        b_item_next.ay.cmax   = a_item_reg.ay.cmax;
        b_item_next.ay.num    = NUM_W'(a_item_reg.ay.dn) * NUM_W'(a_item_reg.ay.sspan);
        b_item_next.ay.den    = a_item_reg.ay.den;
    end

    assign b_ready   = !b_valid_reg || !fifo_full;
    assign a_ready   = !a_valid_reg || b_ready;
    assign s_tready  = a_ready;
    assign push      = b_valid_reg && !fifo_full;
    assign push_item = b_item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            if (a_ready) begin
                a_valid_reg <= s_tvalid;
            end
            if (b_ready) begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (a_ready) begin
            a_item_reg <= a_item_next;
        end
        if (b_ready) begin
            b_item_reg <= b_item_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/nss_fifo.sv
// ----------------------------------------------------------------------------
// nss_fifo
// short queue between the classifying front end and the back end
// ----------------------------------------------------------------------------
`default_nettype none

module nss_fifo
    import nss_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  push,
    input  wire item_t push_item,
    output logic       full,
    input  wire logic  pop,
    output item_t      pop_item,
    output logic       empty
);

    item_t                slot_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg;
    logic [FIFO_AW-1:0]   wr_ptr_next;
    logic [FIFO_AW-1:0]   rd_ptr_reg;
    logic [FIFO_AW-1:0]   rd_ptr_next;
    logic [FIFO_AW:0]     count_reg;
    logic [FIFO_AW:0]     count_next;

    assign full     = (count_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_item = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + FIFO_AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + FIFO_AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + (FIFO_AW+1)'(1);
            2'b01:   count_next = count_reg - (FIFO_AW+1)'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/nss_div.sv
// ----------------------------------------------------------------------------
// nss_div
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
`default_nettype none

module nss_div
    import nss_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             en,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic      [QUO_W-1:0] quo
);

    logic [NUM_W-1:0] rem_reg  [DIV_STAGES];
    logic [DEN_W-1:0] den_reg  [DIV_STAGES];
    logic [QUO_W-1:0] quo_reg  [DIV_STAGES];
    logic [NUM_W-1:0] rem_prev [DIV_STAGES];
    logic [DEN_W-1:0] den_prev [DIV_STAGES];
    logic [QUO_W-1:0] quo_prev [DIV_STAGES];
    logic [NUM_W-1:0] rem_next [DIV_STAGES];
    logic [QUO_W-1:0] quo_next [DIV_STAGES];
    logic [NUM_W:0]   shifted  [DIV_STAGES];
    logic [NUM_W:0]   trial    [DIV_STAGES];

    always_comb begin
        rem_prev[0] = num;
        den_prev[0] = den;
        quo_prev[0] = '0;
        for (int k = 1; k < DIV_STAGES; k++) begin
            rem_prev[k] = rem_reg[k-1];
            den_prev[k] = den_reg[k-1];
            quo_prev[k] = quo_reg[k-1];
        end
    end

    // stage k decides quotient bit DIV_STAGES-1-k
    always_comb begin
        for (int k = 0; k < DIV_STAGES; k++) begin
            shifted[k] = {{(NUM_W+1-DEN_W){1'b0}}, den_prev[k]} << (DIV_STAGES-1-k);
            trial[k]   = {1'b0, rem_prev[k]} - shifted[k];
            if (!trial[k][NUM_W]) begin
                rem_next[k] = trial[k][NUM_W-1:0];
                quo_next[k] = quo_prev[k] | (QUO_W'(1) << (DIV_STAGES-1-k));
            end else begin
                rem_next[k] = rem_prev[k];
                quo_next[k] = quo_prev[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < DIV_STAGES; k++) begin
                rem_reg[k] <= rem_next[k];
                den_reg[k] <= den_prev[k];
                quo_reg[k] <= quo_next[k];
            end
        end
    end

    assign quo = quo_reg[DIV_STAGES-1];

endmodule

`default_nettype wire

FILE: rtl/nss_back.sv
// ----------------------------------------------------------------------------
// nss_back
// divides the center band, clamps, selects per axis and forms the index
// ----------------------------------------------------------------------------
`default_nettype none

module nss_back
    import nss_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic [REG_W-1:0]    src_width,
    input  wire logic                fifo_empty,
    input  wire item_t               fifo_item,
    output logic                     pop,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic      [COORD_W-1:0]  src_x,
    output logic      [COORD_W-1:0]  src_y,
    output logic      [INDEX_W-1:0]  src_index,
    output logic      [ERR_W-1:0]    error_code
);

    typedef struct packed {
        err_t             err;
        logic             cx;
        logic [REG_W-1:0] bx;
        logic [REG_W-1:0] mx;
        logic             cy;
        logic [REG_W-1:0] by;
        logic [REG_W-1:0] my;
    } side_t;

    logic                 en;
    side_t                side_in;
    side_t                side_reg [DIV_STAGES];
    logic                 vld_reg  [DIV_STAGES];
    logic [QUO_W-1:0]     qx;
    logic [QUO_W-1:0]     qy;
    side_t                side_out;
    logic [REG_W:0]       sum_x;
    logic [REG_W:0]       sum_y;
    logic [REG_W-1:0]     sx_next;
    logic [REG_W-1:0]     sy_next;
    logic                 sel_valid_reg;
    logic [REG_W-1:0]     sx_reg;
    logic [REG_W-1:0]     sy_reg;
    err_t                 sel_err_reg;
    logic                 mul_valid_reg;
    logic [2*REG_W-1:0]   prod_reg;
    logic [REG_W-1:0]     mul_sx_reg;
    logic [REG_W-1:0]     mul_sy_reg;
    err_t                 mul_err_reg;
    logic [2*REG_W-1:0]   index_sum;
    logic                 out_valid_reg;
    logic [COORD_W-1:0]   out_x_reg;
    logic [COORD_W-1:0]   out_y_reg;
    logic [INDEX_W-1:0]   out_index_reg;
    err_t                 out_err_reg;

    // whole pipeline holds while a result waits
    assign en  = !out_valid_reg || m_tready;
    assign pop = en && !fifo_empty;

    assign side_in = '{err: fifo_item.err,
                       cx: fifo_item.ax.center, bx: fifo_item.ax.base, mx: fifo_item.ax.cmax,
                       cy: fifo_item.ay.center, by: fifo_item.ay.base, my: fifo_item.ay.cmax};

    nss_div u_div_x (
        .aclk (aclk),
        .en   (en),
        .num  (fifo_item.ax.num),
        .den  (fifo_item.ax.den),
        .quo  (qx)
    );

    nss_div u_div_y (
        .aclk (aclk),
        .en   (en),
        .num  (fifo_item.ay.num),
        .den  (fifo_item.ay.den),
        .quo  (qy)
    );

    assign side_out = side_reg[DIV_STAGES-1];

    // clamp below the far inset
    always_comb begin
        sum_x = {1'b0, side_out.bx} + {1'b0, qx};
        sum_y = {1'b0, side_out.by} + {1'b0, qy};
        if (!side_out.cx) begin
            sx_next = side_out.bx;
        end else if (sum_x > {1'b0, side_out.mx}) begin
            sx_next = side_out.mx;
        end else begin
            sx_next = sum_x[REG_W-1:0];
        end
        if (!side_out.cy) begin
            sy_next = side_out.by;
        end else if (sum_y > {1'b0, side_out.my}) begin
            sy_next = side_out.my;
        end else begin
            sy_next = sum_y[REG_W-1:0];
        end
    end

    assign index_sum = prod_reg + {{REG_W{1'b0}}, mul_sx_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < DIV_STAGES; k++) begin
                vld_reg[k] <= 1'b0;
            end
            sel_valid_reg <= 1'b0;
            mul_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= pop;
            for (int k = 1; k < DIV_STAGES; k++) begin
                vld_reg[k] <= vld_reg[k-1];
            end
            sel_valid_reg <= vld_reg[DIV_STAGES-1];
            mul_valid_reg <= sel_valid_reg;
            out_valid_reg <= mul_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= side_in;
            for (int k = 1; k < DIV_STAGES; k++) begin
                side_reg[k] <= side_reg[k-1];
            end
            sx_reg        <= sx_next;
            sy_reg        <= sy_next;
            sel_err_reg   <= side_out.err;
            prod_reg      <= (2*REG_W)'(sy_reg) * (2*REG_W)'(src_width);
            mul_sx_reg    <= sx_reg;
            mul_sy_reg    <= sy_reg;
            mul_err_reg   <= sel_err_reg;
            out_x_reg     <= mul_sx_reg[COORD_W-1:0];
            out_y_reg     <= mul_sy_reg[COORD_W-1:0];
            out_index_reg <= index_sum[INDEX_W-1:0];
            out_err_reg   <= mul_err_reg;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign src_x      = out_x_reg;
    assign src_y      = out_y_reg;
    assign src_index  = out_index_reg;
    assign error_code = out_err_reg;

endmodule

`default_nettype wire

FILE: rtl/nine_slice_source_address.sv
// ----------------------------------------------------------------------------
// nine_slice_source_address
// nine-slice stretch scaling, nearest neighbor source address generator
// ----------------------------------------------------------------------------
// For each destination pixel word (dst_x, dst_y) the block returns the source
// pixel that nine-slice stretch scaling samples, its linear index
// src_y * src_width + src_x (low 24 bits) and an error code on m_tuser.
// Coordinates inside an inset map directly (near) or from the source's far
// edge (far); the center band is stretched with a multiply and a divide and
// clamped below the far inset. Any configuration error or out-of-target
// coordinate gives error code != 0 and zero coordinates. Throughput is one
// word per clock, sustained unless m_tready stalls the output. The datapath
// has a 13-stage pipelined divider (one quotient bit per stage) and classify,
// multiply, clamp and index stages. A four-word queue separates the
// classifying front end from the divide back end. Configuration registers are
// written through cfg_* by the user only while the block is idle, which the
// block does not enforce; indexes above 7 are ignored. cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module nine_slice_source_address
    import nss_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,

    // configuration write channel
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [REG_W-1:0]     cfg_data,

    // destination coordinate words
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [23:0]          s_tdata,   // [11:0] dst_x, [23:12] dst_y

    // source address words
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [47:0]          m_tdata,   // [11:0] src_x, [23:12] src_y,
                                                 // [47:24] src_index
    output logic      [ERR_W-1:0]     m_tuser    // [2:0] error_code
);

    cfg_t               cfg_reg;
    cfg_t               cfg_next;
    logic               fifo_full;
    logic               fifo_empty;
    logic               push;
    logic               pop;
    item_t              push_item;
    item_t              pop_item;
    logic [COORD_W-1:0] src_x;
    logic [COORD_W-1:0] src_y;
    logic [INDEX_W-1:0] src_index;

    // register file, always ready
    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_SRC_WIDTH:     cfg_next.src_width     = cfg_data;
                REG_SRC_HEIGHT:    cfg_next.src_height    = cfg_data;
                REG_TARGET_WIDTH:  cfg_next.target_width  = cfg_data;
                REG_TARGET_HEIGHT: cfg_next.target_height = cfg_data;
                REG_INSET_LEFT:    cfg_next.inset_left    = cfg_data;
                REG_INSET_RIGHT:   cfg_next.inset_right   = cfg_data;
                REG_INSET_TOP:     cfg_next.inset_top     = cfg_data;
                REG_INSET_BOTTOM:  cfg_next.inset_bottom  = cfg_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    // reset: 1x1 source and target, no insets
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.src_width     <= REG_W'(1);
            cfg_reg.src_height    <= REG_W'(1);
            cfg_reg.target_width  <= REG_W'(1);
            cfg_reg.target_height <= REG_W'(1);
            cfg_reg.inset_left    <= '0;
            cfg_reg.inset_right   <= '0;
            cfg_reg.inset_top     <= '0;
            cfg_reg.inset_bottom  <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // front end: checks, per-axis classification, numerator multiply
    nss_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .dst_x     (s_tdata[11:0]),
        .dst_y     (s_tdata[23:12]),
        .fifo_full (fifo_full),
        .push      (push),
        .push_item (push_item)
    );

    // decoupling queue
    nss_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .full      (fifo_full),
        .pop       (pop),
        .pop_item  (pop_item),
        .empty     (fifo_empty)
    );

    // back end: divide, clamp, index and output register
    nss_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .src_width  (cfg_reg.src_width),
        .fifo_empty (fifo_empty),
        .fifo_item  (pop_item),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .src_x      (src_x),
        .src_y      (src_y),
        .src_index  (src_index),
        .error_code (m_tuser)
    );

    assign m_tdata = {src_index, src_y, src_x};

endmodule

`default_nettype wire

FILE: rtl/nss_checker.sv
// ----------------------------------------------------------------------------
// nss_checker
// port level checks on the result channel, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module nss_checker
    import nss_pkg::*;
(
    input wire logic             aclk,
    input wire logic             aresetn,
    input wire logic             m_tvalid,
    input wire logic             m_tready,
    input wire logic [47:0]      m_tdata,
    input wire logic [ERR_W-1:0] m_tuser
);

    // no result word right after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // an error word carries zero coordinates and index
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != ERR_OK |-> m_tdata == '0)
        else $error("error word with nonzero address");

    a_err_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser <= ERR_COORD)
        else $error("error code out of range");

endmodule

bind nine_slice_source_address nss_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

FILE: dv/tb_nine_slice_source_address.sv
// ----------------------------------------------------------------------------
// tb_nine_slice_source_address
// self-checking bench for the nine-slice source address generator
// ----------------------------------------------------------------------------
// Destination coordinate words are fed from a queue by a clocked driver. Each
// accepted word is run through a local nine-slice mapper to predict the source
// column, row, linear index and error code. A clocked monitor compares every
// result word against the oldest prediction. The run goes through directed
// corner configurations and then random configurations under four idling
// modes. It ends with a long receiver hold-off that backs the block up.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_nine_slice_source_address;
    import nss_pkg::*;

    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 7;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int HOLD_CYCLES   = 300;
    // long enough for the pipeline to empty
    localparam int SETTLE_CYCLES = 40;
    localparam int DIM_LIMIT     = 8191;
    // register index that the block must ignore
    localparam logic [CFG_IDX_W-1:0] REG_NONE = '1;

    typedef struct packed {
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] x;
    } dst_coord_t;

    typedef struct packed {
        logic [COORD_W-1:0] src_x;
        logic [COORD_W-1:0] src_y;
        logic [INDEX_W-1:0] src_index;
        err_t               err;
    } src_addr_t;

    // clock and reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    // configuration channel
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [REG_W-1:0]     cfg_data  = '0;

    // destination coordinate words in
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;   // [11:0] dst_x, [23:12] dst_y

    // source address words out
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [47:0]      m_tdata;    // [11:0] src_x, [23:12] src_y, [47:24] src_index
    logic [ERR_W-1:0] m_tuser;    // [2:0] error_code

    // bench state
    dst_coord_t  pending_coords[$];
    src_addr_t   expected_addrs[$];
    cfg_t        cfg_mirror;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_requests  = 0;
    int unsigned hold_served    = 0;
    int unsigned hold_left      = 0;
    int unsigned cycles         = 0;
    int unsigned mismatches     = 0;

    nine_slice_source_address u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // ------------------------------------------------------------------------
    // mapping of one axis
    // near inset maps straight through, far inset maps from the far edge,
    // the center band is stretched and clamped below the far inset
    // ------------------------------------------------------------------------
    function automatic longint unsigned axis_source(longint unsigned dst,
                                                    longint unsigned target,
                                                    longint unsigned src,
                                                    longint unsigned near,
                                                    longint unsigned far);
        longint unsigned dspan;
        longint unsigned sspan;
        longint unsigned s;
        if (dst < near)
            return dst;
        if (dst + far >= target)
            return src - (target - dst);
        dspan = target - near - far;
        sspan = src - near - far;
        // empty center band falls back to the near inset
        if (dspan == 0 || sspan == 0)
            return near;
        s = near + ((dst - near) * sspan) / dspan;
        if (s >= src - far)
            s = src - far - 1;
        return s;
    endfunction

    // full prediction for one destination word against the current registers
    function automatic src_addr_t predict_source_addr(dst_coord_t d);
        src_addr_t       r;
        longint unsigned sw, sh, tw, th, il, ir, it, ib;
        longint unsigned sx, sy, idx;
        sw = cfg_mirror.src_width;
        sh = cfg_mirror.src_height;
        tw = cfg_mirror.target_width;
        th = cfg_mirror.target_height;
        il = cfg_mirror.inset_left;
        ir = cfg_mirror.inset_right;
        it = cfg_mirror.inset_top;
        ib = cfg_mirror.inset_bottom;
        r = '0;
        // configuration checks in priority order, then the coordinate
        if (sw == 0 || sh == 0 || sw > MAX_DIM || sh > MAX_DIM)
            r.err = ERR_EMPTY_SRC;
        else if (il + ir >= sw)
            r.err = ERR_H_INSET;
        else if (it + ib >= sh)
            r.err = ERR_V_INSET;
        else if (tw < il + ir || th < it + ib)
            r.err = ERR_TARGET;
        else if (d.x >= tw || d.y >= th)
            r.err = ERR_COORD;
        else
            r.err = ERR_OK;
        if (r.err == ERR_OK) begin
            sx  = axis_source(d.x, tw, sw, il, ir);
            sy  = axis_source(d.y, th, sh, it, ib);
            idx = sy * sw + sx;
            r.src_x     = sx[COORD_W-1:0];
            r.src_y     = sy[COORD_W-1:0];
            r.src_index = idx[INDEX_W-1:0];
        end
        return r;
    endfunction

    function automatic cfg_t make_cfg(int unsigned sw, int unsigned sh,
                                      int unsigned tw, int unsigned th,
                                      int unsigned il, int unsigned ir,
                                      int unsigned it, int unsigned ib);
        cfg_t c;
        c.src_width     = sw[REG_W-1:0];
        c.src_height    = sh[REG_W-1:0];
        c.target_width  = tw[REG_W-1:0];
        c.target_height = th[REG_W-1:0];
        c.inset_left    = il[REG_W-1:0];
        c.inset_right   = ir[REG_W-1:0];
        c.inset_top     = it[REG_W-1:0];
        c.inset_bottom  = ib[REG_W-1:0];
        return c;
    endfunction

    task automatic report_mismatch(string what, longint unsigned exp_val,
                                   longint unsigned got_val);
        $display("mismatch at %0t: %s expected %0d got %0d", $realtime, what,
                 exp_val, got_val);
        mismatches++;
    endtask

    // ------------------------------------------------------------------------
    // configuration writes, called only while the block is idle
    // valid stays high across back-to-back writes
    // ------------------------------------------------------------------------
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_SRC_WIDTH:     cfg_mirror.src_width     = data;
            REG_SRC_HEIGHT:    cfg_mirror.src_height    = data;
            REG_TARGET_WIDTH:  cfg_mirror.target_width  = data;
            REG_TARGET_HEIGHT: cfg_mirror.target_height = data;
            REG_INSET_LEFT:    cfg_mirror.inset_left    = data;
            REG_INSET_RIGHT:   cfg_mirror.inset_right   = data;
            REG_INSET_TOP:     cfg_mirror.inset_top     = data;
            REG_INSET_BOTTOM:  cfg_mirror.inset_bottom  = data;
            default: ;
        endcase
    endtask

    task automatic set_config(cfg_t c, bit with_stray);
        @(posedge aclk);
        write_reg(REG_SRC_WIDTH,     c.src_width);
        write_reg(REG_SRC_HEIGHT,    c.src_height);
        write_reg(REG_TARGET_WIDTH,  c.target_width);
        write_reg(REG_TARGET_HEIGHT, c.target_height);
        write_reg(REG_INSET_LEFT,    c.inset_left);
        write_reg(REG_INSET_RIGHT,   c.inset_right);
        write_reg(REG_INSET_TOP,     c.inset_top);
        write_reg(REG_INSET_BOTTOM,  c.inset_bottom);
        // an unused index must leave every register alone
        if (with_stray)
            write_reg(REG_NONE, REG_W'($urandom));
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic queue_coord(int unsigned x, int unsigned y);
        dst_coord_t d;
        d.x = x[COORD_W-1:0];
        d.y = y[COORD_W-1:0];
        pending_coords.push_back(d);
    endtask

    // sender pauses here until every expected word has come back
    task automatic wait_drained();
        do @(negedge aclk);
        while (pending_coords.size() != 0 || expected_addrs.size() != 0);
    endtask

    task automatic check_config_point(cfg_t c, int unsigned x, int unsigned y);
        set_config(c, 1'b0);
        queue_coord(x, y);
        wait_drained();
    endtask

    // one axis of a well-formed configuration: insets fit the source and the
    // target holds both insets
    task automatic pick_axis(output logic [REG_W-1:0] src, output logic [REG_W-1:0] near,
                             output logic [REG_W-1:0] far, output logic [REG_W-1:0] tgt);
        int unsigned s, n, f, lim, span, t;
        case ($urandom_range(3, 0))
            0:       s = $urandom_range(8, 1);
            1:       s = $urandom_range(300, 1);
            2:       s = $urandom_range(MAX_DIM, 1);
            default: s = MAX_DIM;
        endcase
        lim = s - 1;
        n = $urandom_range(1, 0) ? $urandom_range((lim < 16) ? lim : 16, 0)
                                 : $urandom_range(lim, 0);
        lim = s - 1 - n;
        f = $urandom_range(1, 0) ? $urandom_range((lim < 16) ? lim : 16, 0)
                                 : $urandom_range(lim, 0);
        span = n + f;
        case ($urandom_range(3, 0))
            0:       t = span + $urandom_range(40, 0);
            1:       t = span + $urandom_range(1000, 0);
            2:       t = $urandom_range(DIM_LIMIT, span);
            default: t = s;   // same size, identity mapping
        endcase
        src  = s[REG_W-1:0];
        near = n[REG_W-1:0];
        far  = f[REG_W-1:0];
        tgt  = t[REG_W-1:0];
    endtask

    // mostly well-formed, sometimes one register scrambled to hit the errors
    task automatic random_config(output cfg_t c);
        pick_axis(c.src_width, c.inset_left, c.inset_right, c.target_width);
        pick_axis(c.src_height, c.inset_top, c.inset_bottom, c.target_height);
        if ($urandom_range(99, 0) < 15) begin
            case ($urandom_range(7, 0))
                0:       c.src_width     = REG_W'($urandom);
                1:       c.src_height    = REG_W'($urandom);
                2:       c.target_width  = REG_W'($urandom);
                3:       c.target_height = REG_W'($urandom);
                4:       c.inset_left    = REG_W'($urandom);
                5:       c.inset_right   = REG_W'($urandom);
                6:       c.inset_top     = REG_W'($urandom);
                default: c.inset_bottom  = REG_W'($urandom);
            endcase
        end
    endtask

    // coordinates mostly inside the target, the rest anywhere in 12 bits
    task automatic queue_random_coords(int n);
        int unsigned xmax, ymax, x, y;
        xmax = (cfg_mirror.target_width  == 0) ? 0 :
               (cfg_mirror.target_width  > 4096) ? 4095 : cfg_mirror.target_width - 1;
        ymax = (cfg_mirror.target_height == 0) ? 0 :
               (cfg_mirror.target_height > 4096) ? 4095 : cfg_mirror.target_height - 1;
        for (int i = 0; i < n; i++) begin
            x = ($urandom_range(99, 0) < 85) ? $urandom_range(xmax, 0) : $urandom;
            y = ($urandom_range(99, 0) < 85) ? $urandom_range(ymax, 0) : $urandom;
            queue_coord(x, y);
        end
    endtask

    // ------------------------------------------------------------------------
    // driver: presents the head of the pending queue, holds it until taken,
    // predicts the result on acceptance
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_addrs.push_back(predict_source_addr(pending_coords[0]));
                void'(pending_coords.pop_front());
            end
            // a word on offer stays until the handshake
            if (!s_tvalid || s_tready) begin
                if (pending_coords.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= {pending_coords[0].y, pending_coords[0].x};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: checks each result word field by field, drives backpressure
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : monitor
        src_addr_t exp_addr;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_addrs.size() == 0) begin
                    report_mismatch("word with nothing expected, src_index", 0,
                                    m_tdata[47:24]);
                end else begin
                    exp_addr = expected_addrs.pop_front();
                    if (m_tdata[11:0] !== exp_addr.src_x)
                        report_mismatch("src_x", exp_addr.src_x, m_tdata[11:0]);
                    if (m_tdata[23:12] !== exp_addr.src_y)
                        report_mismatch("src_y", exp_addr.src_y, m_tdata[23:12]);
                    if (m_tdata[47:24] !== exp_addr.src_index)
                        report_mismatch("src_index", exp_addr.src_index, m_tdata[47:24]);
                    if (m_tuser !== exp_addr.err)
                        report_mismatch("error_code", exp_addr.err, m_tuser);
                end
            end
            m_tready <= (hold_left == 0) && ($urandom_range(99, 0) >= recv_stall_pct);
        end
    end

    // long receiver hold-off, counted here on request
    always @(posedge aclk) begin
        if (hold_served != hold_requests) begin
            hold_left   <= HOLD_CYCLES;
            hold_served <= hold_served + 1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb_nine_slice_source_address: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        cfg_t c;
        cfg_mirror = make_cfg(1, 1, 1, 1, 0, 0, 0, 0);   // reset values

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset configuration: 1x1 source into a 1x1 target
        queue_coord(0, 0);
        queue_coord(1, 0);
        queue_coord(0, 1);
        queue_coord(4095, 4095);
        wait_drained();

        // upscale with insets, one stray write to an unused index
        set_config(make_cfg(64, 48, 200, 150, 8, 8, 6, 6), 1'b1);
        queue_coord(0, 0);
        queue_coord(7, 5);        // last near-inset pixel
        queue_coord(8, 6);        // first center pixel
        queue_coord(100, 75);
        queue_coord(191, 143);    // last center pixel, clamp edge
        queue_coord(192, 144);    // first far-inset pixel
        queue_coord(199, 149);    // last target pixel
        queue_coord(200, 0);      // column just outside
        queue_coord(0, 150);      // row just outside
        wait_drained();

        // same size is the identity
        set_config(make_cfg(100, 80, 100, 80, 10, 20, 5, 5), 1'b0);
        queue_coord(55, 40);
        queue_coord(99, 79);
        wait_drained();

        // largest source, largest target, no insets
        set_config(make_cfg(MAX_DIM, MAX_DIM, DIM_LIMIT, DIM_LIMIT, 0, 0, 0, 0), 1'b0);
        queue_coord(4095, 4095);
        queue_coord(2730, 1);
        wait_drained();

        // each configuration error
        check_config_point(make_cfg(DIM_LIMIT, 10, 10, 10, 0, 0, 0, 0), 0, 0);
        check_config_point(make_cfg(10, 0, 10, 10, 0, 0, 0, 0), 0, 0);
        check_config_point(make_cfg(10, 10, 10, 10, 5, 5, 0, 0), 0, 0);
        check_config_point(make_cfg(10, 10, 10, 10, 0, 0, 9, 1), 0, 0);
        check_config_point(make_cfg(20, 20, 7, 20, 4, 4, 0, 0), 0, 0);

        // random configurations under each idling mode
        for (int mode = 0; mode < 4; mode++) begin
            case (mode)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 86; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 86; end
                default: begin send_idle_pct = 7;  recv_stall_pct = 7;  end
            endcase
            for (int k = 0; k < 3; k++) begin
                random_config(c);
                set_config(c, $urandom_range(3, 0) == 0);
                queue_random_coords(33);
                wait_drained();
            end
        end

        // receiver holds off while the sender keeps offering: block fills up
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        random_config(c);
        set_config(c, 1'b0);
        hold_requests++;
        queue_random_coords(40);
        wait_drained();

        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (mismatches == 0 && expected_addrs.size() == 0) begin
            $display("tb_nine_slice_source_address: PASS");
        end else begin
            $display("tb_nine_slice_source_address: FAIL");
        end
        $finish;
    end

endmodule
